/* rtl/note_priority_voice_allocator_core_macros.svh */
// Assertion helpers shared by the allocator modules.
`ifndef NOTE_PRIORITY_VOICE_ALLOCATOR_CORE_MACROS_SVH
`define NOTE_PRIORITY_VOICE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define NPVA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npva: assertion failed");

// next-cycle implication
`define NPVA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npva: assertion failed");

`endif

/* rtl/npva_pkg.sv */
package npva_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_VOICES  = 8;

    localparam int KEY_W       = 7;
    localparam int NUM_KEYS    = 1 << KEY_W;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VOICE_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int FC_W        = $clog2(NUM_VOICES + 1);
    localparam int OUT_VOICE_W = 3;
    localparam int ACTION_W    = 2;
    localparam int MODE_W      = 2;
    localparam int ADDR_W      = 3;
    localparam int REG_IDX_W   = ADDR_W - 2;

    localparam logic [MODE_W-1:0] MODE_LEGATO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POLY   = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_RETRIG  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NOTE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

    localparam logic FUNC_OFF = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_MODE = REG_IDX_W'(0);

    typedef struct packed {
        logic latch_in;
        logic set_idx_one;
        logic inc_idx;
        logic shift_step;
        logic dec_count;
        logic push;
        logic res_off;
        logic poly_pop;
        logic map_read;
        logic poly_ret;
        logic load_out;
    } npva_cmd_t;

    typedef struct packed {
        logic              func_off;
        logic [MODE_W-1:0] mode;
        logic              stack_full;
        logic              idx_lt_count;
        logic              match;
        logic              free_empty;
        logic              map_hit;
        logic              slot_free;
    } npva_status_t;

    function automatic logic [OUT_VOICE_W-1:0] to_out_voice(input logic [VOICE_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[OUT_VOICE_W-1:0];
    endfunction

endpackage

/* rtl/npva_dpath.sv */
`include "note_priority_voice_allocator_core_macros.svh"

module npva_dpath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  npva_pkg::npva_cmd_t                  cmd,
    output npva_pkg::npva_status_t               status,
    input  logic [npva_pkg::MODE_W-1:0]          mode,
    input  logic                                 func,
    input  logic [npva_pkg::KEY_W-1:0]           key,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [npva_pkg::OUT_VOICE_W-1:0]     voice,
    output logic [npva_pkg::KEY_W-1:0]           note,
    output logic [npva_pkg::ACTION_W-1:0]        action,
    output logic                                 dropped_oldest
);

    // latched event
    logic                              func_reg;
    logic [npva_pkg::KEY_W-1:0]        key_reg;

    // last-note stack
    logic [npva_pkg::KEY_W-1:0]        held_keys [npva_pkg::STACK_DEPTH];
    logic [npva_pkg::CNT_W-1:0]        held_count_reg;
    logic [npva_pkg::CNT_W-1:0]        idx_reg;
    logic [npva_pkg::CNT_W-1:0]        idx_dec;
    logic [npva_pkg::KEY_W-1:0]        rd_key;
    logic                              dropped_reg;

    // free voice FIFO
    logic [npva_pkg::VOICE_W-1:0]      free_voices_reg [npva_pkg::NUM_VOICES];
    logic [npva_pkg::VOICE_W-1:0]      free_head_reg;
    logic [npva_pkg::VOICE_W-1:0]      free_head_next;
    logic [npva_pkg::FC_W-1:0]         free_count_reg;
    logic [npva_pkg::FC_W:0]           tail_sum;
    logic [npva_pkg::FC_W:0]           tail_wrap;
    logic [npva_pkg::VOICE_W-1:0]      pop_voice;

    // key to voice map
    logic [npva_pkg::VOICE_W-1:0]      map_mem [npva_pkg::NUM_KEYS];
    logic [npva_pkg::NUM_KEYS-1:0]     map_valid_reg;
    logic [npva_pkg::VOICE_W-1:0]      map_rdata_reg;

    // staged result and output slot
    logic [npva_pkg::VOICE_W-1:0]      res_voice_reg;
    logic [npva_pkg::KEY_W-1:0]        res_note_reg;
    logic [npva_pkg::ACTION_W-1:0]     res_action_reg;
    logic                              res_dropped_reg;
    logic                              out_valid_reg;
    logic [npva_pkg::OUT_VOICE_W-1:0]  out_voice_reg;
    logic [npva_pkg::KEY_W-1:0]        out_note_reg;
    logic [npva_pkg::ACTION_W-1:0]     out_action_reg;
    logic                              out_dropped_reg;

    logic                              push_retrig;

    assign idx_dec   = idx_reg - npva_pkg::CNT_W'(1);
    assign rd_key    = held_keys[idx_reg[npva_pkg::IDX_W-1:0]];
    assign pop_voice = free_voices_reg[free_head_reg];

    assign tail_sum  = (npva_pkg::FC_W+1)'(free_head_reg) + (npva_pkg::FC_W+1)'(free_count_reg);
    assign tail_wrap = (tail_sum >= (npva_pkg::FC_W+1)'(npva_pkg::NUM_VOICES))
                     ? tail_sum - (npva_pkg::FC_W+1)'(npva_pkg::NUM_VOICES) : tail_sum;
    assign free_head_next = (free_head_reg == npva_pkg::VOICE_W'(npva_pkg::NUM_VOICES - 1))
                          ? '0 : free_head_reg + npva_pkg::VOICE_W'(1);

    assign push_retrig = (held_count_reg == '0) || (mode == npva_pkg::MODE_MONO);

    always_comb
    begin
        status.func_off     = (func_reg == npva_pkg::FUNC_OFF);
        status.mode         = mode;
        status.stack_full   = (held_count_reg == npva_pkg::CNT_W'(npva_pkg::STACK_DEPTH));
        status.idx_lt_count = (idx_reg < held_count_reg);
        status.match        = (rd_key == key_reg);
        status.free_empty   = (free_count_reg == '0);
        status.map_hit      = map_valid_reg[key_reg];
        status.slot_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg <= func;
            key_reg  <= key;
        end
    end

    // stack storage; removal moves entries down one per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.shift_step)
            held_keys[idx_dec[npva_pkg::IDX_W-1:0]] <= rd_key;
        if (cmd.push)
            held_keys[held_count_reg[npva_pkg::IDX_W-1:0]] <= key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            idx_reg        <= '0;
            dropped_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                idx_reg     <= '0;
                dropped_reg <= 1'b0;
            end
            if (cmd.set_idx_one)
            begin
                idx_reg     <= npva_pkg::CNT_W'(1);
                dropped_reg <= 1'b1;
            end
            if (cmd.inc_idx || cmd.shift_step)
                idx_reg <= idx_reg + npva_pkg::CNT_W'(1);
            if (cmd.dec_count)
            begin
                held_count_reg <= held_count_reg - npva_pkg::CNT_W'(1);
                // point at the new top for the follow-up read
                idx_reg        <= held_count_reg - npva_pkg::CNT_W'(2);
            end
            if (cmd.push)
                held_count_reg <= held_count_reg + npva_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < npva_pkg::NUM_VOICES; i++)
                free_voices_reg[i] <= npva_pkg::VOICE_W'(i);
            free_head_reg  <= '0;
            free_count_reg <= npva_pkg::FC_W'(npva_pkg::NUM_VOICES);
            map_valid_reg  <= '0;
        end
        else
        begin
            if (cmd.poly_pop)
            begin
                free_head_reg          <= free_head_next;
                free_count_reg         <= free_count_reg - npva_pkg::FC_W'(1);
                map_valid_reg[key_reg] <= 1'b1;
            end
            if (cmd.poly_ret)
            begin
                map_valid_reg[key_reg] <= 1'b0;
                if (free_count_reg < npva_pkg::FC_W'(npva_pkg::NUM_VOICES))
                begin
                    free_voices_reg[tail_wrap[npva_pkg::VOICE_W-1:0]] <= map_rdata_reg;
                    free_count_reg <= free_count_reg + npva_pkg::FC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.poly_pop)
            map_mem[key_reg] <= pop_voice;
        if (cmd.map_read)
            map_rdata_reg <= map_mem[key_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            res_voice_reg   <= npva_pkg::VOICE_W'(npva_pkg::NUM_VOICES - 1);
            res_note_reg    <= key_reg;
            res_action_reg  <= push_retrig ? npva_pkg::ACT_RETRIG : npva_pkg::ACT_NOTE;
            res_dropped_reg <= dropped_reg;
        end
        if (cmd.res_off)
        begin
            res_voice_reg   <= npva_pkg::VOICE_W'(npva_pkg::NUM_VOICES - 1);
            res_dropped_reg <= 1'b0;
            if (held_count_reg == '0)
            begin
                res_note_reg   <= key_reg;
                res_action_reg <= npva_pkg::ACT_RELEASE;
            end
            else
            begin
                res_note_reg   <= rd_key;
                res_action_reg <= npva_pkg::ACT_NOTE;
            end
        end
        if (cmd.poly_pop)
        begin
            res_voice_reg   <= pop_voice;
            res_note_reg    <= key_reg;
            res_action_reg  <= npva_pkg::ACT_RETRIG;
            res_dropped_reg <= 1'b0;
        end
        if (cmd.poly_ret)
        begin
            res_voice_reg   <= map_rdata_reg;
            res_note_reg    <= key_reg;
            res_action_reg  <= npva_pkg::ACT_RELEASE;
            res_dropped_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_voice_reg   <= npva_pkg::to_out_voice(res_voice_reg);
            out_note_reg    <= res_note_reg;
            out_action_reg  <= res_action_reg;
            out_dropped_reg <= res_dropped_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign voice          = out_voice_reg;
    assign note           = out_note_reg;
    assign action         = out_action_reg;
    assign dropped_oldest = out_dropped_reg;

    `NPVA_ASSERT_IMP(a_held_bound, clk, rst_n, 1'b1, held_count_reg <= npva_pkg::CNT_W'(npva_pkg::STACK_DEPTH))
    `NPVA_ASSERT_IMP(a_free_bound, clk, rst_n, 1'b1, free_count_reg <= npva_pkg::FC_W'(npva_pkg::NUM_VOICES))
    `NPVA_ASSERT_IMP(a_push_room, clk, rst_n, cmd.push, held_count_reg < npva_pkg::CNT_W'(npva_pkg::STACK_DEPTH))
    `NPVA_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.load_out, out_valid_reg)

endmodule

/* rtl/npva_ctrl.sv */
`include "note_priority_voice_allocator_core_macros.svh"

module npva_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  npva_pkg::npva_status_t status,
    output npva_pkg::npva_cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECODE   = 9'b000000010,
        S_SEARCH   = 9'b000000100,
        S_SHIFT    = 9'b000001000,
        S_PUSH     = 9'b000010000,
        S_OFF_DONE = 9'b000100000,
        S_POLY_ON  = 9'b001000000,
        S_MAP_RD   = 9'b010000000,
        S_EMIT     = 9'b100000000
    } npva_state_t;

    npva_state_t state_reg;
    npva_state_t state_next;
    logic        last_note_mode;

    assign last_note_mode = (status.mode == npva_pkg::MODE_LEGATO)
                         || (status.mode == npva_pkg::MODE_MONO);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (last_note_mode)
                begin
                    if (status.func_off)
                        state_next = S_SEARCH;
                    else if (status.stack_full)
                    begin
                        // drop the oldest: shift everything down from entry one
                        cmd.set_idx_one = 1'b1;
                        state_next      = S_SHIFT;
                    end
                    else
                        state_next = S_PUSH;
                end
                else if (status.mode == npva_pkg::MODE_POLY)
                begin
                    if (status.func_off)
                    begin
                        if (status.map_hit)
                        begin
                            cmd.map_read = 1'b1;
                            state_next   = S_MAP_RD;
                        end
                        else
                            state_next = S_IDLE;
                    end
                    else if (status.free_empty)
                        state_next = S_IDLE;
                    else
                        state_next = S_POLY_ON;
                end
                else
                    state_next = S_IDLE;
            end
            S_SEARCH:
            begin
                if (!status.idx_lt_count)
                    state_next = S_IDLE;
                else
                begin
                    cmd.inc_idx = 1'b1;
                    if (status.match)
                        state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (status.idx_lt_count)
                    cmd.shift_step = 1'b1;
                else
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = status.func_off ? S_OFF_DONE : S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_EMIT;
            end
            S_OFF_DONE:
            begin
                cmd.res_off = 1'b1;
                state_next  = S_EMIT;
            end
            S_POLY_ON:
            begin
                cmd.poly_pop = 1'b1;
                state_next   = S_EMIT;
            end
            S_MAP_RD:
            begin
                cmd.poly_ret = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `NPVA_ASSERT_NXT(a_beat_decodes, clk, rst_n, in_valid && in_ready, state_reg == S_DECODE)
    `NPVA_ASSERT_IMP(a_load_slot, clk, rst_n, cmd.load_out, status.slot_free)
    `NPVA_ASSERT_IMP(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg))

endmodule

/* rtl/note_priority_voice_allocator_core.sv */
// A note-on with stack room or a poly event passes S_DECODE and then S_PUSH, S_POLY_ON or S_MAP_RD
// before S_EMIT; a last-note note-off makes one serial pass over the held keys (search up to the
// match, shift-down above it), and a note-on into a full stack adds a shift pass that drops the oldest.
// One event in flight; the next beat is taken the cycle after the result is loaded into the output
// register, and the load waits in S_EMIT until the output slot is free.
// Reset (rst_n low, async): empty stack, voices free in order, key map invalid, legato mode.
module note_priority_voice_allocator_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [npva_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 func,
    input  logic [npva_pkg::KEY_W-1:0]           key,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [npva_pkg::OUT_VOICE_W-1:0]     voice,
    output logic [npva_pkg::KEY_W-1:0]           note,
    output logic [npva_pkg::ACTION_W-1:0]        action,
    output logic                                 dropped_oldest
);

    logic [npva_pkg::MODE_W-1:0] mode_reg;
    logic                        mode_sel;
    npva_pkg::npva_cmd_t         cmd;
    npva_pkg::npva_status_t      status;

    assign mode_sel = (paddr[npva_pkg::ADDR_W-1:2] == npva_pkg::REG_MODE);
    assign pready   = 1'b1;
    assign prdata   = mode_sel ? 32'(mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= npva_pkg::MODE_LEGATO;
        else if (psel && penable && pwrite && mode_sel)
            mode_reg <= pwdata[npva_pkg::MODE_W-1:0];
    end

    npva_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    npva_dpath u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .mode           (mode_reg),
        .func           (func),
        .key            (key),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .voice          (voice),
        .note           (note),
        .action         (action),
        .dropped_oldest (dropped_oldest)
    );

endmodule

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT        = 21;
    localparam int DRAIN_CYCLES    = 2 * npva_pkg::STACK_DEPTH + 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_ROUNDS   = 13;
    localparam int ROUND_EVENTS    = 40;

    localparam logic [npva_pkg::MODE_W-1:0]      MODE_UNUSED = 2'd3;
    localparam logic                             FUNC_ON     = ~npva_pkg::FUNC_OFF;
    localparam logic [npva_pkg::OUT_VOICE_W-1:0] LAST_VOICE  =
        npva_pkg::OUT_VOICE_W'(npva_pkg::NUM_VOICES - 1);

    typedef struct packed {
        logic [npva_pkg::OUT_VOICE_W-1:0] voice;
        logic [npva_pkg::KEY_W-1:0]       note;
        logic [npva_pkg::ACTION_W-1:0]    action;
        logic                             dropped;
    } voice_cmd_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [npva_pkg::ADDR_W-1:0]      paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             func = 1'b0;
    logic [npva_pkg::KEY_W-1:0]       key = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [npva_pkg::OUT_VOICE_W-1:0] voice;
    logic [npva_pkg::KEY_W-1:0]       note;
    logic [npva_pkg::ACTION_W-1:0]    action;
    logic                             dropped_oldest;

    // predictor state
    logic [npva_pkg::MODE_W-1:0]      cur_mode = npva_pkg::MODE_LEGATO;
    logic [npva_pkg::KEY_W-1:0]       held_stack [npva_pkg::STACK_DEPTH];
    int                               held_cnt = 0;
    logic [npva_pkg::VOICE_W-1:0]     free_fifo [npva_pkg::NUM_VOICES];
    int                               free_cnt = npva_pkg::NUM_VOICES;
    bit                               key_mapped [npva_pkg::NUM_KEYS];
    logic [npva_pkg::VOICE_W-1:0]     key_voice [npva_pkg::NUM_KEYS];

    voice_cmd_t             pending_cmds [$];

    int  events_sent = 0;
    int  cmds_checked = 0;
    int  drops_seen = 0;
    int  errors = 0;
    int  cycle_count = 0;
    bit  steady = 1'b0;
    int  stall_seq = 0;
    int  stall_seen = 0;
    int  hold_left = 0;

    note_priority_voice_allocator_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .key            (key),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .voice          (voice),
        .note           (note),
        .action         (action),
        .dropped_oldest (dropped_oldest)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < npva_pkg::NUM_VOICES; i++)
            free_fifo[i] = npva_pkg::VOICE_W'(i);
        for (int i = 0; i < npva_pkg::NUM_KEYS; i++)
        begin
            key_mapped[i] = 1'b0;
            key_voice[i] = '0;
        end
    end

    function automatic bit idle_roll();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Updates the allocator state for one event; returns 1 when a command results.
    function automatic bit allocate_voice(input logic f, input logic [npva_pkg::KEY_W-1:0] k,
                                          output voice_cmd_t cmd);
        int i;
        int hit;
        logic [npva_pkg::VOICE_W-1:0] v;
        cmd = '0;
        if (cur_mode == npva_pkg::MODE_LEGATO || cur_mode == npva_pkg::MODE_MONO)
        begin
            cmd.voice = LAST_VOICE;
            if (f == FUNC_ON)
            begin
                cmd.action = (held_cnt == 0 || cur_mode == npva_pkg::MODE_MONO)
                           ? npva_pkg::ACT_RETRIG : npva_pkg::ACT_NOTE;
                if (held_cnt >= npva_pkg::STACK_DEPTH)
                begin
                    for (i = 0; i < npva_pkg::STACK_DEPTH - 1; i++)
                        held_stack[i] = held_stack[i + 1];
                    held_cnt = npva_pkg::STACK_DEPTH - 1;
                    cmd.dropped = 1'b1;
                end
                held_stack[held_cnt] = k;
                held_cnt++;
                cmd.note = k;
                return 1'b1;
            end
            hit = -1;
            for (i = 0; i < held_cnt; i++)
                if (hit < 0 && held_stack[i] == k)
                    hit = i;
            if (hit < 0)
                return 1'b0;
            for (i = hit; i < held_cnt - 1; i++)
                held_stack[i] = held_stack[i + 1];
            held_cnt--;
            if (held_cnt == 0)
            begin
                cmd.note = k;
                cmd.action = npva_pkg::ACT_RELEASE;
            end
            else
            begin
                cmd.note = held_stack[held_cnt - 1];
                cmd.action = npva_pkg::ACT_NOTE;
            end
            return 1'b1;
        end
        if (cur_mode == npva_pkg::MODE_POLY)
        begin
            if (f == FUNC_ON)
            begin
                if (free_cnt == 0)
                    return 1'b0;
                v = free_fifo[0];
                for (i = 0; i < free_cnt - 1; i++)
                    free_fifo[i] = free_fifo[i + 1];
                free_cnt--;
                // a key already mapped just gets the new voice; the old one is lost
                key_mapped[k] = 1'b1;
                key_voice[k] = v;
                cmd.action = npva_pkg::ACT_RETRIG;
            end
            else
            begin
                if (!key_mapped[k])
                    return 1'b0;
                v = key_voice[k];
                key_mapped[k] = 1'b0;
                if (free_cnt < npva_pkg::NUM_VOICES)
                begin
                    free_fifo[free_cnt] = v;
                    free_cnt++;
                end
                cmd.action = npva_pkg::ACT_RELEASE;
            end
            cmd.voice = npva_pkg::OUT_VOICE_W'(v);
            cmd.note = k;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic play_event(input logic f, input logic [npva_pkg::KEY_W-1:0] k);
        voice_cmd_t cmd;
        while (idle_roll())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        key <= k;
        do
            @(posedge clk);
        while (!in_ready);
        events_sent++;
        if (allocate_voice(f, k, cmd))
            pending_cmds.insert(pending_cmds.size(), cmd);
    endtask

    // Well-formed last-note traffic: mostly held keys released, some repeats and strays.
    task automatic play_last_note_step();
        logic [npva_pkg::KEY_W-1:0] k;
        if (held_cnt == 0 || $urandom_range(99) < 52)
        begin
            if (held_cnt > 0 && $urandom_range(99) < 30)
                k = held_stack[$urandom_range(held_cnt - 1)];
            else
                k = npva_pkg::KEY_W'($urandom_range(npva_pkg::NUM_KEYS - 1));
            play_event(FUNC_ON, k);
        end
        else
        begin
            if ($urandom_range(99) < 85)
                k = held_stack[$urandom_range(held_cnt - 1)];
            else
                k = npva_pkg::KEY_W'($urandom_range(npva_pkg::NUM_KEYS - 1));
            play_event(npva_pkg::FUNC_OFF, k);
        end
    endtask

    task automatic pick_mapped_key(output bit found, output logic [npva_pkg::KEY_W-1:0] k);
        logic [npva_pkg::KEY_W-1:0] mapped [$];
        for (int i = 0; i < npva_pkg::NUM_KEYS; i++)
            if (key_mapped[i])
                mapped.insert(mapped.size(), npva_pkg::KEY_W'(i));
        found = mapped.size() > 0;
        k = found ? mapped[$urandom_range(mapped.size() - 1)] : '0;
    endtask

    // Poly traffic never re-strikes a sounding key, so no voice gets lost here.
    task automatic play_poly_step();
        logic [npva_pkg::KEY_W-1:0] k;
        bit found;
        k = npva_pkg::KEY_W'($urandom_range(npva_pkg::NUM_KEYS - 1));
        if ($urandom_range(99) < 55)
        begin
            play_event(key_mapped[k] ? npva_pkg::FUNC_OFF : FUNC_ON, k);
        end
        else
        begin
            pick_mapped_key(found, k);
            if (!found || $urandom_range(99) < 15)
                k = npva_pkg::KEY_W'($urandom_range(npva_pkg::NUM_KEYS - 1));
            play_event(npva_pkg::FUNC_OFF, k);
        end
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic [npva_pkg::MODE_W-1:0] m);
        settle_block();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {npva_pkg::REG_MODE, 2'b00};
        pwdata <= 32'(m);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[npva_pkg::MODE_W-1:0] !== m)
        begin
            $display("%0t: mode readback mismatch expected %0d actual %0d",
                     $time, m, prdata[npva_pkg::MODE_W-1:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        cur_mode = m;
    endtask

    task automatic test_legato_basics();
        set_mode(npva_pkg::MODE_LEGATO);
        play_event(FUNC_ON, 7'd0);
        play_event(FUNC_ON, 7'd127);
        play_event(FUNC_ON, 7'd0);
        play_event(npva_pkg::FUNC_OFF, 7'd5);
        play_event(npva_pkg::FUNC_OFF, 7'd0);
        play_event(npva_pkg::FUNC_OFF, 7'd0);
        play_event(npva_pkg::FUNC_OFF, 7'd127);
    endtask

    task automatic test_mono_retrigger();
        set_mode(npva_pkg::MODE_MONO);
        play_event(FUNC_ON, 7'd85);
        play_event(FUNC_ON, 7'd42);
        play_event(npva_pkg::FUNC_OFF, 7'd85);
        play_event(npva_pkg::FUNC_OFF, 7'd42);
    endtask

    task automatic test_poly_allocation();
        set_mode(npva_pkg::MODE_POLY);
        play_event(FUNC_ON, 7'd60);
        play_event(FUNC_ON, 7'd60);
        play_event(npva_pkg::FUNC_OFF, 7'd60);
        play_event(npva_pkg::FUNC_OFF, 7'd60);
        play_event(FUNC_ON, 7'd127);
        play_event(npva_pkg::FUNC_OFF, 7'd0);
        play_event(npva_pkg::FUNC_OFF, 7'd127);
    endtask

    task automatic test_unused_mode();
        set_mode(MODE_UNUSED);
        play_event(FUNC_ON, 7'd10);
        play_event(npva_pkg::FUNC_OFF, 7'd10);
    endtask

    task automatic test_stack_overflow(input logic [npva_pkg::MODE_W-1:0] m, input int ons);
        set_mode(m);
        repeat (ons)
            play_event(FUNC_ON, npva_pkg::KEY_W'($urandom_range(npva_pkg::NUM_KEYS - 1)));
        while (held_cnt > 0)
            play_event(npva_pkg::FUNC_OFF, held_stack[$urandom_range(held_cnt - 1)]);
    endtask

    task automatic test_poly_exhaust();
        logic [npva_pkg::KEY_W-1:0] k;
        bit found;
        set_mode(npva_pkg::MODE_POLY);
        while (free_cnt > 0)
        begin
            k = npva_pkg::KEY_W'($urandom_range(npva_pkg::NUM_KEYS - 1));
            if (!key_mapped[k])
                play_event(FUNC_ON, k);
        end
        repeat (3)
            play_event(FUNC_ON, npva_pkg::KEY_W'($urandom_range(npva_pkg::NUM_KEYS - 1)));
        pick_mapped_key(found, k);
        while (found)
        begin
            play_event(npva_pkg::FUNC_OFF, k);
            pick_mapped_key(found, k);
        end
    endtask

    // Output held off long enough that the block backs up into its input.
    task automatic test_output_backpressure();
        set_mode(npva_pkg::MODE_LEGATO);
        stall_seq <= stall_seq + 1;
        repeat (14)
            play_last_note_step();
    endtask

    task automatic test_random_mix();
        logic [npva_pkg::MODE_W-1:0] m;
        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            m = (r < 3) ? npva_pkg::MODE_W'(r) : npva_pkg::MODE_W'($urandom_range(2));
            set_mode(m);
            steady <= (r == 6);
            repeat (ROUND_EVENTS)
            begin
                if (m == npva_pkg::MODE_POLY)
                    play_poly_step();
                else
                    play_last_note_step();
            end
        end
        steady <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_seq != stall_seen)
        begin
            stall_seen = stall_seq;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !idle_roll();
        end
    end

    always @(posedge clk)
    begin
        voice_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: unexpected beat voice=%0d note=%0d action=%0d dropped=%0d",
                         $time, voice, note, action, dropped_oldest);
                errors++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                cmds_checked++;
                if (dropped_oldest)
                    drops_seen++;
                if (voice !== want.voice || note !== want.note || action !== want.action
                    || dropped_oldest !== want.dropped)
                begin
                    $display("%0t: mismatch expected voice=%0d note=%0d action=%0d dropped=%0d",
                             $time, want.voice, want.note, want.action, want.dropped);
                    $display("%0t:          actual voice=%0d note=%0d action=%0d dropped=%0d",
                             $time, voice, note, action, dropped_oldest);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_cmds.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_legato_basics();
        test_mono_retrigger();
        test_poly_allocation();
        test_unused_mode();
        test_stack_overflow(npva_pkg::MODE_MONO, npva_pkg::STACK_DEPTH + 4);
        test_stack_overflow(npva_pkg::MODE_LEGATO, npva_pkg::STACK_DEPTH + 2);
        test_poly_exhaust();
        test_output_backpressure();
        test_random_mix();

        settle_block();
        $display("Ran %0d events in legato, mono, poly and unused modes, with stack overflow,",
                 events_sent);
        $display("voice exhaustion and a long output stall; %0d commands checked, %0d drops.",
                 cmds_checked, drops_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
